### src/line_pair_closest_approach_macros.svh
// Assertion macros for the line pair closest approach block
`ifndef LINE_PAIR_CLOSEST_APPROACH_MACROS_SVH
`define LINE_PAIR_CLOSEST_APPROACH_MACROS_SVH

// checked outside reset
`define LPCA_CHK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked in reset as well
`define LPCA_CHK_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

### src/lpca_pkg.sv
// Constants and types for the line pair closest approach block
package lpca_pkg;

    localparam int FrontStages = 9;
    localparam int DivSteps    = 41;
    localparam int SqrtSteps   = 32;
    localparam int Depth       = FrontStages + 1 + DivSteps + 6 + 1 + SqrtSteps + 1;

    localparam logic [30:0] PrecReset = 31'd66;
    localparam logic [30:0] GapMax    = 31'h7FFF_FFFF;
    localparam logic [63:0] ParDen    = 64'd1 << 28;
    localparam logic [40:0] QSat      = 41'd1 << 40;

    localparam logic signed [42:0] SatHi = 43'sd2147483647;
    localparam logic signed [42:0] SatLo = -43'sd2147483648;

    // cross product operand order
    localparam int CrJ [3] = '{1, 2, 0};
    localparam int CrK [3] = '{2, 0, 1};

    typedef logic signed [31:0] t_coord;
    typedef logic signed [15:0] t_dir;

endpackage

### src/line_pair_closest_approach.sv
// Line pair closest approach: deep pipeline with divider and square root
//
// Input channel (s_axis): one transfer carries two 3D lines, each a Q16.16
// foot point and a Q1.14 direction. Output channel (m_axis): one transfer per
// input with both closest points, their distance (gap) and the parallel and
// intersect flags. The user must write the precision register through
// i_cfg_wen / i_cfg_wdata only while no item is in flight; the block does
// not enforce this. Throughput is one item per cycle while the receiver does
// not stall: 9 front stages (cross products, split multiplies, numerator
// build), a 41 stage restoring divider with six lanes, 6 point and distance
// stages and a 32 stage square root, each retiring one bit per stage.
// Reset clears all valid bits and loads precision with 66.
// When the receiver stalls the whole pipeline holds; s_axis tready follows
// m_axis tready whenever the output register is full, and is high otherwise.
`include "line_pair_closest_approach_macros.svh"

module line_pair_closest_approach (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_wen,
    input  logic [30:0]  i_cfg_wdata,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // foot_a_x,y,z; dir_a_x,y,z; foot_b_x,y,z; dir_b_x,y,z
    input  logic [287:0] i_s_axis_tdata,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // near_a_x,y,z; near_b_x,y,z; gap; zero pad
    output logic [223:0] o_m_axis_tdata,
    // is_parallel; meets
    output logic [1:0]   o_m_axis_tuser
);

    localparam int Dv = lpca_pkg::DivSteps;
    localparam int Sq = lpca_pkg::SqrtSteps;

    logic ce;
    logic [lpca_pkg::Depth-1:0] r_vld;
    logic [30:0] r_prec;
    logic [63:0] r_psq;
    logic        r_pbig;
    logic [61:0] r_msq;

    lpca_pkg::t_coord in_fa [3];
    lpca_pkg::t_coord in_fb [3];
    lpca_pkg::t_dir   in_da [3];
    lpca_pkg::t_dir   in_db [3];

    // stage A
    lpca_pkg::t_coord r_a_fa [3];
    lpca_pkg::t_coord r_a_fb [3];
    lpca_pkg::t_dir   r_a_da [3];
    lpca_pkg::t_dir   r_a_db [3];
    logic signed [32:0] r_a_c [3];
    logic signed [32:0] r_a_w [3];
    // stage B
    lpca_pkg::t_coord r_b_fa [3];
    lpca_pkg::t_coord r_b_fb [3];
    lpca_pkg::t_dir   r_b_da [3];
    lpca_pkg::t_dir   r_b_db [3];
    logic signed [32:0] r_b_c [3];
    logic [63:0]        r_b_csq [3];
    logic signed [48:0] r_b_ep [3];
    logic signed [48:0] r_b_en [3];
    logic signed [48:0] r_b_gp [3];
    logic signed [48:0] r_b_gn [3];
    logic signed [48:0] r_b_dt [3];
    // stage C
    lpca_pkg::t_coord r_c_fa [3];
    lpca_pkg::t_coord r_c_fb [3];
    lpca_pkg::t_dir   r_c_da [3];
    lpca_pkg::t_dir   r_c_db [3];
    logic signed [32:0] r_c_c [3];
    logic [63:0]        r_c_s;
    logic signed [49:0] r_c_e [3];
    logic signed [49:0] r_c_g [3];
    logic signed [50:0] r_c_dot;
    // stage D
    lpca_pkg::t_coord r_d_fa [3];
    lpca_pkg::t_coord r_d_fb [3];
    lpca_pkg::t_dir   r_d_da [3];
    lpca_pkg::t_dir   r_d_db [3];
    logic [63:0]        r_d_s;
    logic               r_d_par;
    logic signed [58:0] r_d_ce_lo [3];
    logic signed [57:0] r_d_ce_hi [3];
    logic signed [58:0] r_d_cg_lo [3];
    logic signed [57:0] r_d_cg_hi [3];
    logic signed [42:0] r_d_pd_lo [3];
    logic signed [40:0] r_d_pd_hi [3];
    // stage E
    lpca_pkg::t_coord r_e_fa [3];
    lpca_pkg::t_coord r_e_fb [3];
    lpca_pkg::t_dir   r_e_da [3];
    lpca_pkg::t_dir   r_e_db [3];
    logic [63:0]        r_e_s;
    logic               r_e_par;
    logic signed [84:0] r_e_n0;
    logic signed [84:0] r_e_n1;
    logic signed [66:0] r_e_pn [3];
    // stage F
    lpca_pkg::t_coord r_f_fa [3];
    lpca_pkg::t_coord r_f_fb [3];
    logic [63:0]        r_f_s;
    logic               r_f_par;
    logic signed [66:0] r_f_pn [3];
    logic signed [44:0] r_f_lo [6];
    logic signed [44:0] r_f_mid [6];
    logic signed [44:0] r_f_hi [6];
    // stage G
    lpca_pkg::t_coord r_g_foot [6];
    logic [63:0]         r_g_den;
    logic                r_g_par;
    logic signed [101:0] r_g_num [6];
    // stage H
    lpca_pkg::t_coord r_h_foot [6];
    logic [63:0]  r_h_den;
    logic         r_h_par;
    logic         r_h_neg [6];
    logic [101:0] r_h_mag [6];
    // stage I
    lpca_pkg::t_coord r_i_foot [6];
    logic [63:0]  r_i_den;
    logic         r_i_par;
    logic         r_i_neg [6];
    logic [101:0] r_i_m [6];
    // divider
    lpca_pkg::t_coord r_dv_foot [Dv+1][6];
    logic [63:0]   r_dv_den [Dv+1];
    logic          r_dv_par [Dv+1];
    logic          r_dv_neg [Dv+1][6];
    logic          r_dv_sat [Dv+1][6];
    logic [63:0]   r_dv_rem [Dv+1][6];
    logic [Dv-1:0] r_dv_low [Dv+1][6];
    logic [Dv-1:0] r_dv_q   [Dv+1][6];
    logic [64:0]   dv_t  [Dv][6];
    logic          dv_ge [Dv][6];
    // points
    logic [40:0]        k1_q [6];
    lpca_pkg::t_coord   r_k1_foot [6];
    logic signed [41:0] r_k1_off [6];
    logic               r_k1_par;
    logic signed [42:0] k2_sum [6];
    lpca_pkg::t_coord   r_k2_pt [6];
    logic               r_k2_par;
    lpca_pkg::t_coord   r_l1_pt [6];
    logic signed [32:0] r_l1_d [3];
    logic               r_l1_par;
    lpca_pkg::t_coord   r_l2_pt [6];
    logic [31:0]        r_l2_m [3];
    logic               r_l2_par;
    lpca_pkg::t_coord   r_m_pt [6];
    logic [63:0]        r_m_sq [3];
    logic               r_m_par;
    lpca_pkg::t_coord   r_n_pt [6];
    logic [65:0]        r_n_sum;
    logic               r_n_par;
    // square root
    lpca_pkg::t_coord r_sq_pt [Sq+1][6];
    logic          r_sq_par   [Sq+1];
    logic          r_sq_over  [Sq+1];
    logic          r_sq_meets [Sq+1];
    logic [63:0]   r_sq_x     [Sq+1];
    logic [33:0]   r_sq_rem   [Sq+1];
    logic [Sq-1:0] r_sq_root  [Sq+1];
    logic [35:0]   sq_t  [Sq];
    logic          sq_ge [Sq];
    // output
    lpca_pkg::t_coord r_out_pt [6];
    logic [30:0] r_out_gap;
    logic        r_out_par;
    logic        r_out_meets;

    assign ce = !r_vld[lpca_pkg::Depth-1] || i_m_axis_tready;
    assign o_s_axis_tready = ce;
    assign o_m_axis_tvalid = r_vld[lpca_pkg::Depth-1];
    assign o_m_axis_tdata  = {1'b0, r_out_gap, r_out_pt[5], r_out_pt[4], r_out_pt[3],
                              r_out_pt[2], r_out_pt[1], r_out_pt[0]};
    assign o_m_axis_tuser  = {r_out_meets, r_out_par};

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            in_fa[i] = i_s_axis_tdata[32*i +: 32];
            in_da[i] = i_s_axis_tdata[96 + 16*i +: 16];
            in_fb[i] = i_s_axis_tdata[144 + 32*i +: 32];
            in_db[i] = i_s_axis_tdata[240 + 16*i +: 16];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_prec <= lpca_pkg::PrecReset;
        end else begin
            if (ce) begin
                r_vld <= {r_vld[lpca_pkg::Depth-2:0], i_s_axis_tvalid};
            end
            if (i_cfg_wen) begin
                r_prec <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_psq  <= 64'({r_prec[19:0], 12'b0}) * 64'({r_prec[19:0], 12'b0});
        r_pbig <= r_prec[30:20] != '0;
        r_msq  <= 62'(r_prec) * 62'(r_prec);
    end

    // front: cross products, squared length, numerators
    always_ff @(posedge i_clk) begin
        if (ce) begin
            for (int i = 0; i < 3; i++) begin
                r_a_fa[i] <= in_fa[i];
                r_a_fb[i] <= in_fb[i];
                r_a_da[i] <= in_da[i];
                r_a_db[i] <= in_db[i];
                r_a_c[i]  <= 33'(in_da[lpca_pkg::CrJ[i]]) * 33'(in_db[lpca_pkg::CrK[i]])
                           - 33'(in_da[lpca_pkg::CrK[i]]) * 33'(in_db[lpca_pkg::CrJ[i]]);
                r_a_w[i]  <= 33'(in_fb[i]) - 33'(in_fa[i]);

                r_b_fa[i]  <= r_a_fa[i];
                r_b_fb[i]  <= r_a_fb[i];
                r_b_da[i]  <= r_a_da[i];
                r_b_db[i]  <= r_a_db[i];
                r_b_c[i]   <= r_a_c[i];
                r_b_csq[i] <= 64'(64'(r_a_c[i]) * 64'(r_a_c[i]));
                r_b_ep[i]  <= 49'(r_a_w[lpca_pkg::CrJ[i]]) * 49'(r_a_db[lpca_pkg::CrK[i]]);
                r_b_en[i]  <= 49'(r_a_w[lpca_pkg::CrK[i]]) * 49'(r_a_db[lpca_pkg::CrJ[i]]);
                r_b_gp[i]  <= 49'(r_a_w[lpca_pkg::CrJ[i]]) * 49'(r_a_da[lpca_pkg::CrK[i]]);
                r_b_gn[i]  <= 49'(r_a_w[lpca_pkg::CrK[i]]) * 49'(r_a_da[lpca_pkg::CrJ[i]]);
                r_b_dt[i]  <= 49'(r_a_db[i]) * 49'(r_a_w[i]);

                r_c_fa[i] <= r_b_fa[i];
                r_c_fb[i] <= r_b_fb[i];
                r_c_da[i] <= r_b_da[i];
                r_c_db[i] <= r_b_db[i];
                r_c_c[i]  <= r_b_c[i];
                r_c_e[i]  <= 50'(r_b_ep[i]) - 50'(r_b_en[i]);
                r_c_g[i]  <= 50'(r_b_gp[i]) - 50'(r_b_gn[i]);

                r_d_fa[i] <= r_c_fa[i];
                r_d_fb[i] <= r_c_fb[i];
                r_d_da[i] <= r_c_da[i];
                r_d_db[i] <= r_c_db[i];
                r_d_ce_lo[i] <= 59'(r_c_c[i]) * 59'($signed({1'b0, r_c_e[i][24:0]}));
                r_d_ce_hi[i] <= 58'(r_c_c[i]) * 58'($signed(r_c_e[i][49:25]));
                r_d_cg_lo[i] <= 59'(r_c_c[i]) * 59'($signed({1'b0, r_c_g[i][24:0]}));
                r_d_cg_hi[i] <= 58'(r_c_c[i]) * 58'($signed(r_c_g[i][49:25]));
                r_d_pd_lo[i] <= 43'(r_c_db[i]) * 43'($signed({1'b0, r_c_dot[25:0]}));
                r_d_pd_hi[i] <= 41'(r_c_db[i]) * 41'($signed(r_c_dot[50:26]));

                r_e_fa[i] <= r_d_fa[i];
                r_e_fb[i] <= r_d_fb[i];
                r_e_da[i] <= r_d_da[i];
                r_e_db[i] <= r_d_db[i];
                r_e_pn[i] <= (67'(r_d_pd_hi[i]) <<< 26) + 67'(r_d_pd_lo[i]);

                r_f_fa[i] <= r_e_fa[i];
                r_f_fb[i] <= r_e_fb[i];
                r_f_pn[i] <= r_e_pn[i];
                r_f_lo[i]    <= 45'(r_e_da[i]) * 45'($signed({1'b0, r_e_n0[27:0]}));
                r_f_mid[i]   <= 45'(r_e_da[i]) * 45'($signed({1'b0, r_e_n0[55:28]}));
                r_f_hi[i]    <= 45'(r_e_da[i]) * 45'($signed(r_e_n0[84:56]));
                r_f_lo[i+3]  <= 45'(r_e_db[i]) * 45'($signed({1'b0, r_e_n1[27:0]}));
                r_f_mid[i+3] <= 45'(r_e_db[i]) * 45'($signed({1'b0, r_e_n1[55:28]}));
                r_f_hi[i+3]  <= 45'(r_e_db[i]) * 45'($signed(r_e_n1[84:56]));

                r_g_foot[i]   <= r_f_fa[i];
                r_g_foot[i+3] <= r_f_fb[i];
            end
            r_c_s   <= r_b_csq[0] + r_b_csq[1] + r_b_csq[2];
            r_c_dot <= 51'sd0 - 51'(r_b_dt[0]) - 51'(r_b_dt[1]) - 51'(r_b_dt[2]);

            r_d_s   <= r_c_s;
            r_d_par <= r_pbig || (r_c_s <= r_psq);

            r_e_s   <= r_d_s;
            r_e_par <= r_d_par;
            r_e_n0  <= (85'(r_d_ce_hi[0]) <<< 25) + 85'(r_d_ce_lo[0])
                     + (85'(r_d_ce_hi[1]) <<< 25) + 85'(r_d_ce_lo[1])
                     + (85'(r_d_ce_hi[2]) <<< 25) + 85'(r_d_ce_lo[2]);
            r_e_n1  <= (85'(r_d_cg_hi[0]) <<< 25) + 85'(r_d_cg_lo[0])
                     + (85'(r_d_cg_hi[1]) <<< 25) + 85'(r_d_cg_lo[1])
                     + (85'(r_d_cg_hi[2]) <<< 25) + 85'(r_d_cg_lo[2]);

            r_f_s   <= r_e_s;
            r_f_par <= r_e_par;

            r_g_par <= r_f_par;
            r_g_den <= r_f_par ? lpca_pkg::ParDen : r_f_s;
            for (int l = 0; l < 6; l++) begin
                if (r_f_par) begin
                    r_g_num[l] <= (l < 3) ? 102'sd0 : 102'(r_f_pn[l % 3]);
                end else begin
                    r_g_num[l] <= (102'(r_f_hi[l]) <<< 56) + (102'(r_f_mid[l]) <<< 28)
                                + 102'(r_f_lo[l]);
                end
            end

            r_h_den <= r_g_den;
            r_h_par <= r_g_par;
            r_i_den <= r_h_den;
            r_i_par <= r_h_par;
            for (int l = 0; l < 6; l++) begin
                r_h_foot[l] <= r_g_foot[l];
                r_h_neg[l]  <= r_g_num[l][101];
                r_h_mag[l]  <= r_g_num[l][101] ? 102'(-r_g_num[l]) : 102'(r_g_num[l]);
                r_i_foot[l] <= r_h_foot[l];
                r_i_neg[l]  <= r_h_neg[l];
                r_i_m[l]    <= r_h_mag[l] + 102'(r_h_den >> 1);
            end
        end
    end

    // restoring divider, one quotient bit per stage
    always_comb begin
        for (int k = 0; k < Dv; k++) begin
            for (int l = 0; l < 6; l++) begin
                dv_t[k][l]  = {r_dv_rem[k][l], r_dv_low[k][l][Dv-1]};
                dv_ge[k][l] = dv_t[k][l] >= {1'b0, r_dv_den[k]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_dv_den[0] <= r_i_den;
            r_dv_par[0] <= r_i_par;
            for (int l = 0; l < 6; l++) begin
                r_dv_foot[0][l] <= r_i_foot[l];
                r_dv_neg[0][l]  <= r_i_neg[l];
                r_dv_sat[0][l]  <= 64'(r_i_m[l][101:Dv]) >= r_i_den;
                r_dv_rem[0][l]  <= 64'(r_i_m[l][101:Dv]);
                r_dv_low[0][l]  <= r_i_m[l][Dv-1:0];
                r_dv_q[0][l]    <= '0;
            end
            for (int k = 0; k < Dv; k++) begin
                r_dv_den[k+1] <= r_dv_den[k];
                r_dv_par[k+1] <= r_dv_par[k];
                for (int l = 0; l < 6; l++) begin
                    r_dv_foot[k+1][l] <= r_dv_foot[k][l];
                    r_dv_neg[k+1][l]  <= r_dv_neg[k][l];
                    r_dv_sat[k+1][l]  <= r_dv_sat[k][l];
                    r_dv_rem[k+1][l]  <= dv_ge[k][l] ? 64'(dv_t[k][l] - {1'b0, r_dv_den[k]})
                                                     : 64'(dv_t[k][l]);
                    r_dv_low[k+1][l]  <= r_dv_low[k][l] << 1;
                    r_dv_q[k+1][l]    <= {r_dv_q[k][l][Dv-2:0], dv_ge[k][l]};
                end
            end
        end
    end

    // points and squared distance
    always_comb begin
        for (int l = 0; l < 6; l++) begin
            k1_q[l]   = (r_dv_sat[Dv][l] || (r_dv_q[Dv][l] > lpca_pkg::QSat))
                        ? lpca_pkg::QSat : r_dv_q[Dv][l];
            k2_sum[l] = 43'(r_k1_foot[l]) + 43'(r_k1_off[l]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_k1_par <= r_dv_par[Dv];
            r_k2_par <= r_k1_par;
            r_l1_par <= r_k2_par;
            r_l2_par <= r_l1_par;
            r_m_par  <= r_l2_par;
            r_n_par  <= r_m_par;
            for (int l = 0; l < 6; l++) begin
                r_k1_foot[l] <= r_dv_foot[Dv][l];
                r_k1_off[l]  <= r_dv_neg[Dv][l] ? 42'sd0 - $signed({1'b0, k1_q[l]})
                                                : $signed({1'b0, k1_q[l]});
                if (k2_sum[l] > lpca_pkg::SatHi) begin
                    r_k2_pt[l] <= lpca_pkg::SatHi[31:0];
                end else if (k2_sum[l] < lpca_pkg::SatLo) begin
                    r_k2_pt[l] <= lpca_pkg::SatLo[31:0];
                end else begin
                    r_k2_pt[l] <= k2_sum[l][31:0];
                end
                r_l1_pt[l] <= r_k2_pt[l];
                r_l2_pt[l] <= r_l1_pt[l];
                r_m_pt[l]  <= r_l2_pt[l];
                r_n_pt[l]  <= r_m_pt[l];
            end
            for (int i = 0; i < 3; i++) begin
                r_l1_d[i] <= 33'(r_k2_pt[i]) - 33'(r_k2_pt[i+3]);
                r_l2_m[i] <= r_l1_d[i][32] ? 32'(-r_l1_d[i]) : 32'(r_l1_d[i]);
                r_m_sq[i] <= 64'(r_l2_m[i]) * 64'(r_l2_m[i]);
            end
            r_n_sum <= 66'(r_m_sq[0]) + 66'(r_m_sq[1]) + 66'(r_m_sq[2]);
        end
    end

    // square root, one root bit per stage
    always_comb begin
        for (int k = 0; k < Sq; k++) begin
            sq_t[k]  = {r_sq_rem[k], r_sq_x[k][63:62]};
            sq_ge[k] = sq_t[k] >= 36'({r_sq_root[k], 2'b01});
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_sq_par[0]   <= r_n_par;
            r_sq_over[0]  <= r_n_sum[65:64] != 2'b00;
            r_sq_meets[0] <= (r_n_sum[65:64] == 2'b00) && (r_n_sum[63:0] <= 64'(r_msq));
            r_sq_x[0]     <= r_n_sum[63:0];
            r_sq_rem[0]   <= '0;
            r_sq_root[0]  <= '0;
            for (int l = 0; l < 6; l++) begin
                r_sq_pt[0][l] <= r_n_pt[l];
            end
            for (int k = 0; k < Sq; k++) begin
                r_sq_par[k+1]   <= r_sq_par[k];
                r_sq_over[k+1]  <= r_sq_over[k];
                r_sq_meets[k+1] <= r_sq_meets[k];
                r_sq_x[k+1]     <= r_sq_x[k] << 2;
                r_sq_rem[k+1]   <= sq_ge[k] ? 34'(sq_t[k] - 36'({r_sq_root[k], 2'b01}))
                                            : 34'(sq_t[k]);
                r_sq_root[k+1]  <= {r_sq_root[k][Sq-2:0], sq_ge[k]};
                for (int l = 0; l < 6; l++) begin
                    r_sq_pt[k+1][l] <= r_sq_pt[k][l];
                end
            end

            r_out_par   <= r_sq_par[Sq];
            r_out_meets <= r_sq_meets[Sq];
            r_out_gap   <= (r_sq_over[Sq] || r_sq_root[Sq][Sq-1]) ? lpca_pkg::GapMax
                                                                  : r_sq_root[Sq][30:0];
            for (int l = 0; l < 6; l++) begin
                r_out_pt[l] <= r_sq_pt[Sq][l];
            end
        end
    end

    `LPCA_CHK(a_meets_gap, (o_m_axis_tvalid && o_m_axis_tuser[1]) |-> (r_out_gap <= r_prec), "meets flagged with gap above precision")
    `LPCA_CHK_RST(a_rst_empty, !i_rst_n |=> !o_m_axis_tvalid, "output valid right after reset")
    `LPCA_CHK(a_ready_free, !o_m_axis_tvalid |-> o_s_axis_tready, "input stalled with empty output")

endmodule
